// ===== src/cppm_pkg.sv =====
// Shared types, codes and constants for the controller port packet master.
`timescale 1ns / 1ps

package cppm_pkg;

    // Default size of the request byte store.
    localparam int MAX_REQUEST_DEF = 8;
    // Cap on the response length register.
    localparam int MAX_RESPONSE    = 32;

    localparam int FuncW = 3;
    localparam int KindW = 2;
    localparam int ByteW = 8;
    localparam int LenW  = 6;
    localparam int DlyW  = 8;
    localparam int TmoW  = 10;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 10;

    // Input function codes.
    localparam logic [FuncW-1:0] FUNC_LOAD  = 3'd0;
    localparam logic [FuncW-1:0] FUNC_START = 3'd1;
    localparam logic [FuncW-1:0] FUNC_RXBYTE = 3'd2;
    localparam logic [FuncW-1:0] FUNC_ACK   = 3'd3;
    localparam logic [FuncW-1:0] FUNC_TICK  = 3'd4;

    // Result kinds.
    localparam logic [KindW-1:0] KIND_TX   = 2'd0;
    localparam logic [KindW-1:0] KIND_RESP = 2'd1;
    localparam logic [KindW-1:0] KIND_DONE = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_DEV_ADDR = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MAX_LEN  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SEL_DLY  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ACK_TMO  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_PORT_SEL = 3'd4;

    // Register reset values.
    localparam logic [ByteW-1:0] RST_DEV_ADDR = 8'h01;
    localparam logic [LenW-1:0]  RST_MAX_LEN  = 6'd8;
    localparam logic [DlyW-1:0]  RST_SEL_DLY  = 8'd60;
    localparam logic [TmoW-1:0]  RST_ACK_TMO  = 10'd120;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] byte_value;
        logic [LenW-1:0]  response_length;
        logic             chip_select;
        logic             selected_port;
    } t_result;

endpackage

// ===== src/cppm_out_buf.sv =====
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps

module cppm_out_buf
    import cppm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // skid full: no push can arrive, drain into the output register
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== src/controller_port_packet_master.sv =====
// Top level of the controller port packet master sequencer.
`timescale 1ns / 1ps
// Each result is registered in the output register, or the skid stage if that is stalled.
// Throughput: one item per cycle while o_stall is low, each a single registered state update.
// The two-entry result buffer raises o_stall only while both of its entries are held.
// Reset (i_rst_n low at a clock edge): sequencer idle, chip select released, counts and
// timer cleared, registers back to defaults; the request store keeps stale contents.

module controller_port_packet_master
    import cppm_pkg::*;
#(
    parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [FuncW-1:0]    i_func,
    input  logic [ByteW-1:0]    i_data,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [KindW-1:0]    o_kind,
    output logic [ByteW-1:0]    o_byte_value,
    output logic [LenW-1:0]     o_response_length,
    output logic                o_chip_select,
    output logic                o_selected_port,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    localparam int CntW = $clog2(MAX_REQUEST + 1);
    localparam int IdxW = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
    localparam int MaxRespClip = (MAX_RESPONSE > 63) ? 63 : MAX_RESPONSE;
    localparam logic [LenW-1:0] MaxRespW = LenW'(MaxRespClip);
    localparam logic [CntW-1:0] MaxReqW  = CntW'(MAX_REQUEST);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEL_WAIT,
        PH_ADDR_ACK,
        PH_XFER_RX,
        PH_XFER_ACK,
        PH_REL_WAIT
    } t_phase;

    // configuration registers
    logic [ByteW-1:0] r_dev_addr;
    logic [LenW-1:0]  r_max_len;
    logic [DlyW-1:0]  r_sel_dly;
    logic [TmoW-1:0]  r_ack_tmo;
    logic             r_port_sel;

    // sequencer state
    t_phase           r_phase,        n_phase;
    logic [CntW-1:0]  r_req_count,    n_req_count;
    logic [CntW-1:0]  r_send_index,   n_send_index;
    logic [LenW-1:0]  r_recv_count,   n_recv_count;
    logic [TmoW-1:0]  r_timer,        n_timer;
    logic             r_ack,          n_ack;
    logic             r_port,         n_port;
    logic             r_cs,           n_cs;

    logic [ByteW-1:0] r_req_store [MAX_REQUEST];

    logic             accept;
    logic             buf_full;
    logic             push;
    logic [1:0]       res_sel;       // which result this item makes, if any
    logic [ByteW-1:0] res_byte;
    logic [TmoW-1:0]  timer_inc;
    logic [TmoW-1:0]  sel_dly_ext;
    logic [LenW-1:0]  eff_max;
    logic             store_wr;
    t_result          result;
    t_result          out_result;

    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_TX   = 2'd1;
    localparam logic [1:0] RES_RESP = 2'd2;
    localparam logic [1:0] RES_DONE = 2'd3;

    assign accept      = i_valid && !buf_full;
    assign o_stall     = buf_full;
    assign o_cfg_ready = 1'b1;

    assign timer_inc   = r_timer + TmoW'(1);
    assign sel_dly_ext = TmoW'(r_sel_dly);
    assign eff_max     = (r_max_len > MaxRespW) ? MaxRespW : r_max_len;

    // Configuration writes; unknown indexes fall through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= RST_DEV_ADDR;
            r_max_len  <= RST_MAX_LEN;
            r_sel_dly  <= RST_SEL_DLY;
            r_ack_tmo  <= RST_ACK_TMO;
            r_port_sel <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEV_ADDR: r_dev_addr <= i_cfg_data[ByteW-1:0];
                REG_MAX_LEN:  r_max_len  <= i_cfg_data[LenW-1:0];
                REG_SEL_DLY:  r_sel_dly  <= i_cfg_data[DlyW-1:0];
                REG_ACK_TMO:  r_ack_tmo  <= i_cfg_data[TmoW-1:0];
                REG_PORT_SEL: r_port_sel <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // One pass over the item: next state and the result it makes.
    always_comb begin
        n_phase      = r_phase;
        n_req_count  = r_req_count;
        n_send_index = r_send_index;
        n_recv_count = r_recv_count;
        n_timer      = r_timer;
        n_ack        = r_ack;
        n_port       = r_port;
        n_cs         = r_cs;
        res_sel      = RES_NONE;
        res_byte     = '0;
        store_wr     = 1'b0;

        case (i_func)
            FUNC_LOAD: begin
                // fill the store while idle; drop loads beyond its depth
                if (r_phase == PH_IDLE && r_req_count < MaxReqW) begin
                    store_wr    = 1'b1;
                    n_req_count = r_req_count + CntW'(1);
                end
            end
            FUNC_START: begin
                if (r_phase == PH_IDLE) begin
                    n_port       = r_port_sel;
                    n_cs         = 1'b1;
                    n_ack        = 1'b0;
                    n_timer      = '0;
                    n_send_index = '0;
                    n_recv_count = '0;
                    n_phase      = PH_SEL_WAIT;
                end
            end
            FUNC_RXBYTE: begin
                // forward only an awaited byte; drop stray ones
                if (r_phase == PH_XFER_RX) begin
                    n_recv_count = r_recv_count + LenW'(1);
                    if (r_send_index < r_req_count) begin
                        n_send_index = r_send_index + CntW'(1);
                    end
                    n_timer  = '0;
                    n_phase  = PH_XFER_ACK;
                    res_sel  = RES_RESP;
                    res_byte = i_data;
                end
            end
            FUNC_ACK: begin
                if (r_phase != PH_IDLE) begin
                    n_ack = 1'b1;
                end
            end
            FUNC_TICK: begin
                case (r_phase)
                    PH_SEL_WAIT: begin
                        n_timer = timer_inc;
                        if (timer_inc >= sel_dly_ext) begin
                            n_timer  = '0;
                            n_phase  = PH_ADDR_ACK;
                            res_sel  = RES_TX;
                            res_byte = r_dev_addr;
                        end
                    end
                    PH_ADDR_ACK, PH_XFER_ACK: begin
                        if (r_ack) begin
                            // consume the latched acknowledge
                            n_ack   = 1'b0;
                            n_timer = '0;
                            if (r_recv_count >= eff_max) begin
                                n_phase = PH_REL_WAIT;
                            end else begin
                                n_phase = PH_XFER_RX;
                                res_sel = RES_TX;
                                if (r_send_index < r_req_count) begin
                                    res_byte = r_req_store[r_send_index[IdxW-1:0]];
                                end
                            end
                        end else begin
                            n_timer = timer_inc;
                            if (timer_inc >= r_ack_tmo) begin
                                n_timer = '0;
                                n_phase = PH_REL_WAIT;
                            end
                        end
                    end
                    PH_REL_WAIT: begin
                        n_timer = timer_inc;
                        if (timer_inc >= sel_dly_ext) begin
                            // release select and report; next packet needs a fresh load
                            n_timer      = '0;
                            n_cs         = 1'b0;
                            n_phase      = PH_IDLE;
                            n_req_count  = '0;
                            n_send_index = '0;
                            res_sel      = RES_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        result.byte_value      = res_byte;
        result.chip_select     = n_cs;
        result.selected_port   = n_port;
        result.response_length = '0;
        case (res_sel)
            RES_RESP: result.kind = KIND_RESP;
            RES_DONE: begin
                result.kind            = KIND_DONE;
                result.response_length = r_recv_count;
            end
            default:  result.kind = KIND_TX;
        endcase
    end

    assign push = accept && (res_sel != RES_NONE);

    // Hold the sequencer state; advance only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_req_count  <= '0;
            r_send_index <= '0;
            r_recv_count <= '0;
            r_timer      <= '0;
            r_ack        <= 1'b0;
            r_port       <= 1'b0;
            r_cs         <= 1'b0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_req_count  <= n_req_count;
            r_send_index <= n_send_index;
            r_recv_count <= n_recv_count;
            r_timer      <= n_timer;
            r_ack        <= n_ack;
            r_port       <= n_port;
            r_cs         <= n_cs;
        end
    end

    // Request byte store: written at the fill count, read at the send index.
    always_ff @(posedge i_clk) begin
        if (accept && store_wr) begin
            r_req_store[r_req_count[IdxW-1:0]] <= i_data;
        end
    end

    cppm_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_full   (buf_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_kind            = out_result.kind;
    assign o_byte_value      = out_result.byte_value;
    assign o_response_length = out_result.response_length;
    assign o_chip_select     = out_result.chip_select;
    assign o_selected_port   = out_result.selected_port;

endmodule

// ===== dv/controller_port_packet_master_tb.sv =====
// Self-checking testbench for the controller port packet master sequencer.
`timescale 1ns / 1ps

module controller_port_packet_master_tb;
    import cppm_pkg::*;

    // Request store depth of the instance under test.
    localparam int REQ_DEPTH      = MAX_REQUEST_DEF;
    // Cycles with no handshake on any channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 1000;

    // Function codes that the sequencer must ignore.
    localparam logic [FuncW-1:0] FUNC_RSVD_LO = 3'd5;
    localparam logic [FuncW-1:0] FUNC_RSVD_HI = 3'd7;

    // Packet phases of the sequencer as the predictor tracks them.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SEL_WAIT,
        SEQ_ADDR_ACK,
        SEQ_XFER_RX,
        SEQ_XFER_ACK,
        SEQ_REL_WAIT
    } t_seq_phase;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [FuncW-1:0]    i_func;
    logic [ByteW-1:0]    i_data;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [KindW-1:0]    o_kind;
    logic [ByteW-1:0]    o_byte_value;
    logic [LenW-1:0]     o_response_length;
    logic                o_chip_select;
    logic                o_selected_port;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;

    controller_port_packet_master i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_data            (i_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_byte_value      (o_byte_value),
        .o_response_length (o_response_length),
        .o_chip_select     (o_chip_select),
        .o_selected_port   (o_selected_port),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // 12 ns period, low half first.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Sequencer predictor: its own copy of the registers and packet state.
    // ------------------------------------------------------------------
    logic [ByteW-1:0] cfg_dev_addr;
    logic [LenW-1:0]  cfg_max_len;
    logic [DlyW-1:0]  cfg_sel_dly;
    logic [TmoW-1:0]  cfg_ack_tmo;
    logic             cfg_port;

    t_seq_phase       pkt_phase;
    logic [ByteW-1:0] req_store [REQ_DEPTH];
    int unsigned      req_count;
    int unsigned      tx_index;
    int unsigned      rx_count;
    int unsigned      us_timer;
    logic             ack_seen;
    logic             cs_port;
    logic             cs_level;

    // Results predicted but not yet taken from the block, oldest first.
    t_result owed_results [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Idling odds in percent for the sender gaps and the receiver stalls.
    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left = 0;

    // Packet plan for the random stimulus: loads before start, and the number
    // of response bytes after which acknowledges stop coming.
    int plan_loads = 0;
    int loads_sent = 0;
    int plan_acks  = 1;

    function automatic void reset_sequencer();
        cfg_dev_addr = RST_DEV_ADDR;
        cfg_max_len  = RST_MAX_LEN;
        cfg_sel_dly  = RST_SEL_DLY;
        cfg_ack_tmo  = RST_ACK_TMO;
        cfg_port     = 1'b0;
        pkt_phase    = SEQ_IDLE;
        req_count    = 0;
        tx_index     = 0;
        rx_count     = 0;
        us_timer     = 0;
        ack_seen     = 1'b0;
        cs_port      = 1'b0;
        cs_level     = 1'b0;
    endfunction

    // Advance the predicted sequencer by one item; return 1 when it yields a result.
    function automatic bit sequencer_step(input logic [FuncW-1:0] func,
                                          input logic [ByteW-1:0] data,
                                          output t_result res);
        bit               emit;
        logic [KindW-1:0] kind;
        logic [ByteW-1:0] value;
        logic [LenW-1:0]  len;
        int unsigned      len_cap;
        emit    = 1'b0;
        kind    = KIND_TX;
        value   = '0;
        len     = '0;
        // The length register is capped at the response limit.
        len_cap = (cfg_max_len > MAX_RESPONSE) ? MAX_RESPONSE : cfg_max_len;
        case (func)
            FUNC_LOAD: begin
                // Loads only while idle; drop them once the store is full.
                if (pkt_phase == SEQ_IDLE && req_count < REQ_DEPTH) begin
                    req_store[req_count] = data;
                    req_count++;
                end
            end
            FUNC_START: begin
                if (pkt_phase == SEQ_IDLE) begin
                    cs_port   = cfg_port;
                    cs_level  = 1'b1;
                    ack_seen  = 1'b0;
                    us_timer  = 0;
                    tx_index  = 0;
                    rx_count  = 0;
                    pkt_phase = SEQ_SEL_WAIT;
                end
            end
            FUNC_RXBYTE: begin
                // Forward only the awaited byte; stray bytes are dropped.
                if (pkt_phase == SEQ_XFER_RX) begin
                    rx_count++;
                    if (tx_index < req_count) begin
                        tx_index++;
                    end
                    us_timer  = 0;
                    pkt_phase = SEQ_XFER_ACK;
                    emit      = 1'b1;
                    kind      = KIND_RESP;
                    value     = data;
                end
            end
            FUNC_ACK: begin
                if (pkt_phase != SEQ_IDLE) begin
                    ack_seen = 1'b1;
                end
            end
            FUNC_TICK: begin
                case (pkt_phase)
                    SEQ_SEL_WAIT: begin
                        us_timer++;
                        if (us_timer >= cfg_sel_dly) begin
                            us_timer  = 0;
                            pkt_phase = SEQ_ADDR_ACK;
                            emit      = 1'b1;
                            value     = cfg_dev_addr;
                        end
                    end
                    SEQ_ADDR_ACK, SEQ_XFER_ACK: begin
                        if (ack_seen) begin
                            ack_seen = 1'b0;
                            us_timer = 0;
                            if (rx_count >= len_cap) begin
                                pkt_phase = SEQ_REL_WAIT;
                            end else begin
                                // Send the next request byte, or zero once used up.
                                pkt_phase = SEQ_XFER_RX;
                                emit      = 1'b1;
                                if (tx_index < req_count) begin
                                    value = req_store[tx_index];
                                end
                            end
                        end else begin
                            us_timer++;
                            if (us_timer >= cfg_ack_tmo) begin
                                us_timer  = 0;
                                pkt_phase = SEQ_REL_WAIT;
                            end
                        end
                    end
                    SEQ_REL_WAIT: begin
                        us_timer++;
                        if (us_timer >= cfg_sel_dly) begin
                            us_timer  = 0;
                            cs_level  = 1'b0;
                            pkt_phase = SEQ_IDLE;
                            req_count = 0;
                            tx_index  = 0;
                            emit      = 1'b1;
                            kind      = KIND_DONE;
                            len       = rx_count[LenW-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.kind            = kind;
        res.byte_value      = value;
        res.response_length = len;
        res.chip_select     = cs_level;
        res.selected_port   = cs_port;
        return emit;
    endfunction

    // ------------------------------------------------------------------
    // Handshake helpers. Every task is entered and left just after a
    // rising edge; handshakes are sampled on the falling edge, where all
    // inputs and registered outputs are settled.
    // ------------------------------------------------------------------

    // Send one item, after an optional gap, and predict its result.
    task automatic send_item(input logic [FuncW-1:0] func, input logic [ByteW-1:0] data);
        bit      taken;
        t_result res;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_data  <= data;
        // Hold the item until the block takes it.
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        if (sequencer_step(func, data, res)) begin
            owed_results.push_back(res);
        end
    endtask

    // Stop sending and wait for every owed result, then some spare cycles.
    task automatic wait_results(input int spare);
        i_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (spare) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        bit ready_seen;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            ready_seen = o_cfg_ready;
            @(posedge i_clk);
        end while (!ready_seen);
        case (idx)
            REG_DEV_ADDR: cfg_dev_addr = value[ByteW-1:0];
            REG_MAX_LEN:  cfg_max_len  = value[LenW-1:0];
            REG_SEL_DLY:  cfg_sel_dly  = value[DlyW-1:0];
            REG_ACK_TMO:  cfg_ack_tmo  = value[TmoW-1:0];
            REG_PORT_SEL: cfg_port     = value[0];
            default: ;
        endcase
    endtask

    // Write all five registers; the unused upper data bits carry noise.
    task automatic write_registers(input logic [ByteW-1:0] addr, input logic [LenW-1:0] max_len,
                                   input logic [DlyW-1:0] sel_dly, input logic [TmoW-1:0] ack_tmo,
                                   input logic port);
        logic [CfgDataW-1:0] pad;
        pad = CfgDataW'($urandom);
        cfg_write(REG_DEV_ADDR, {pad[CfgDataW-1:ByteW], addr});
        cfg_write(REG_MAX_LEN,  {pad[CfgDataW-1:LenW], max_len});
        cfg_write(REG_SEL_DLY,  {pad[CfgDataW-1:DlyW], sel_dly});
        cfg_write(REG_ACK_TMO,  ack_tmo);
        cfg_write(REG_PORT_SEL, {pad[CfgDataW-1:1], port});
        i_cfg_valid <= 1'b0;
    endtask

    // Pick idling odds for a phase; a calm phase has none on either side.
    task automatic set_traffic(input bit calm);
        gap_pct   = calm ? 0 : 15 * $urandom_range(0, 3);
        stall_pct = calm ? 0 : 15 * $urandom_range(0, 3);
    endtask

    // Choose the next item from the predicted phase. Most items push the
    // packet along; a few are random codes. Draining acknowledges every wait
    // and only closes the packet.
    task automatic pick_item(input bit drain, output logic [FuncW-1:0] func,
                             output logic [ByteW-1:0] data);
        int  roll;
        bit  want_ack;
        roll = $urandom_range(0, 99);
        data = ByteW'($urandom_range(0, 255));
        func = FuncW'($urandom_range(0, 7));
        want_ack = (pkt_phase == SEQ_ADDR_ACK) ? (plan_acks > 0) : (rx_count < plan_acks);
        if (drain) begin
            case (pkt_phase)
                SEQ_XFER_RX:                func = FUNC_RXBYTE;
                SEQ_ADDR_ACK, SEQ_XFER_ACK: func = ack_seen ? FUNC_TICK : FUNC_ACK;
                default:                    func = FUNC_TICK;
            endcase
        end else if (roll >= 9) begin
            case (pkt_phase)
                SEQ_IDLE: begin
                    if (loads_sent < plan_loads) begin
                        func = FUNC_LOAD;
                        loads_sent++;
                    end else begin
                        // Start the packet and plan the next one.
                        func       = FUNC_START;
                        plan_loads = $urandom_range(0, REQ_DEPTH + 2);
                        loads_sent = 0;
                        plan_acks  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                SEQ_ADDR_ACK, SEQ_XFER_ACK: begin
                    func = (!ack_seen && want_ack && roll < 75) ? FUNC_ACK : FUNC_TICK;
                end
                SEQ_XFER_RX: func = FUNC_RXBYTE;
                default:     func = FUNC_TICK;
            endcase
        end
    endtask

    // Run random items, then close the open packet and let the results drain.
    task automatic run_random(input int n_items);
        logic [FuncW-1:0] func;
        logic [ByteW-1:0] data;
        repeat (n_items) begin
            pick_item(1'b0, func, data);
            send_item(func, data);
            // Now and then hold off until the block has caught up.
            if ($urandom_range(0, 99) == 0) begin
                wait_results(1);
            end
        end
        while (pkt_phase != SEQ_IDLE) begin
            pick_item(1'b1, func, data);
            send_item(func, data);
        end
        wait_results(4);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register values out of reset, with no write yet.
    task automatic test_reset_defaults();
        set_traffic(1'b0);
        run_random(100);
    endtask

    // One short packet by hand: ignored codes and idle events, busy loads
    // and starts, a stale byte before the address acknowledge, request bytes
    // at both extremes, and the end on the length limit.
    task automatic test_basic_exchange();
        set_traffic(1'b0);
        write_registers(8'hFF, 6'd2, 8'd1, 10'd2, 1'b1);
        send_item(FUNC_RSVD_LO, 8'h00);
        send_item(FUNC_RSVD_HI, 8'hFF);
        send_item(FUNC_ACK,     8'hAA);
        send_item(FUNC_TICK,    8'h00);
        send_item(FUNC_RXBYTE,  8'h55);
        send_item(FUNC_LOAD,    8'h00);
        send_item(FUNC_LOAD,    8'hFF);
        send_item(FUNC_START,   8'h00);
        send_item(FUNC_LOAD,    8'h77);
        send_item(FUNC_START,   8'h00);
        send_item(FUNC_TICK,    8'h00);
        send_item(FUNC_RXBYTE,  8'h3C);
        send_item(FUNC_ACK,     8'h00);
        send_item(FUNC_TICK,    8'h00);
        send_item(FUNC_RXBYTE,  8'hFF);
        send_item(FUNC_ACK,     8'h00);
        send_item(FUNC_TICK,    8'h00);
        send_item(FUNC_RXBYTE,  8'h80);
        send_item(FUNC_ACK,     8'h00);
        send_item(FUNC_TICK,    8'h00);
        send_item(FUNC_TICK,    8'h00);
        wait_results(4);
    endtask

    // Zero delay, timeout and length: an acknowledge latched during the
    // select wait, a zero-length end, and an immediate timeout.
    task automatic test_zero_registers();
        set_traffic(1'b0);
        write_registers(8'h00, 6'd0, 8'd0, 10'd0, 1'b0);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_ACK,   8'h00);
        send_item(FUNC_TICK,  8'h00);
        send_item(FUNC_TICK,  8'h00);
        send_item(FUNC_TICK,  8'h00);
        send_item(FUNC_START, 8'h00);
        send_item(FUNC_TICK,  8'h00);
        send_item(FUNC_TICK,  8'h00);
        send_item(FUNC_TICK,  8'h00);
        wait_results(4);
        run_random(100);
    endtask

    // Long responses up to the cap, and a length register above it.
    task automatic test_long_responses();
        set_traffic(1'b0);
        write_registers(ByteW'($urandom_range(0, 255)), 6'd32, 8'd1, 10'd3, 1'b1);
        run_random(150);
        write_registers(ByteW'($urandom_range(0, 255)), 6'd63, 8'd2, 10'd1023, 1'b0);
        run_random(100);
    endtask

    // Longest select delay and acknowledge timeout.
    task automatic test_slow_select();
        set_traffic(1'b0);
        write_registers(8'hAA, 6'd1, 8'd255, 10'd1023, 1'b1);
        run_random(250);
    endtask

    // Several random settings with short delays.
    task automatic test_random_settings();
        repeat (4) begin
            set_traffic(1'b0);
            write_registers(ByteW'($urandom_range(0, 255)), LenW'($urandom_range(0, 40)),
                            DlyW'($urandom_range(0, 5)), TmoW'($urandom_range(0, 8)),
                            1'($urandom_range(0, 1)));
            run_random(100);
        end
    endtask

    // Back-to-back items with no idling on either side.
    task automatic test_steady_stream();
        set_traffic(1'b1);
        write_registers(ByteW'($urandom_range(0, 255)), LenW'($urandom_range(1, 32)),
                        DlyW'($urandom_range(1, 3)), TmoW'($urandom_range(1, 6)),
                        1'($urandom_range(0, 1)));
        run_random(200);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall in bursts of random length, with the stall released
    // between one burst and the next.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!i_stall && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker: compare each result taken with the oldest owed one.
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (owed_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result at %0t ns", $realtime);
                    $display("  expected: none");
                    $display("  actual:   kind %0d byte %02h len %0d cs %0b port %0b",
                             o_kind, o_byte_value, o_response_length, o_chip_select,
                             o_selected_port);
                end
            end else begin
                want = owed_results.pop_front();
                if (o_kind !== want.kind || o_byte_value !== want.byte_value ||
                    o_response_length !== want.response_length ||
                    o_chip_select !== want.chip_select ||
                    o_selected_port !== want.selected_port) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result mismatch at %0t ns", $realtime);
                        $display("  expected: kind %0d byte %02h len %0d cs %0b port %0b",
                                 want.kind, want.byte_value, want.response_length,
                                 want.chip_select, want.selected_port);
                        $display("  actual:   kind %0d byte %02h len %0d cs %0b port %0b",
                                 o_kind, o_byte_value, o_response_length, o_chip_select,
                                 o_selected_port);
                    end
                end
            end
        end
    end

    // Watchdog: give up when no channel has moved for too long.
    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_func      <= FUNC_LOAD;
        i_data      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_DEV_ADDR;
        i_cfg_data  <= '0;
        reset_sequencer();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_basic_exchange();
        test_zero_registers();
        test_long_responses();
        test_slow_select();
        test_random_settings();
        test_steady_stream();

        // Let any late result show up before the verdict.
        wait_results(10);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
